// ===== rtl/vmpc_pkg.sv =====
// vmpc_pkg: types, constants and small helpers of the vibration motor pattern controller
// used by vmpc_slow, vmpc_core and vibration_motor_pattern_controller_unit
`default_nettype none

package vmpc_pkg;

   localparam logic [6:0] TICKS_PER_STEP = 7'd100;
   localparam logic [6:0] PWM_PERIOD     = 7'd100;

   localparam logic [7:0] HOLD_MIN   = 8'd8;
   localparam logic [7:0] HOLD_MAX   = 8'd200;
   localparam logic [7:0] IDLE_LIMIT = 8'd200;

   localparam logic [6:0] FLASH_STEPS  = 7'd100;
   localparam logic [6:0] BLINK_PERIOD = 7'd100;
   localparam logic [6:0] BLINK_ON     = 7'd50;

   localparam int KEY_COUNT  = 5;
   localparam int KEY_POWER  = 0;
   localparam int KEY_MODE_A = 1;
   localparam int KEY_MODE_B = 2;
   localparam int KEY_FASTER = 3;
   localparam int KEY_SLOWER = 4;

   localparam logic [1:0] CH_OFF = 2'd0;
   localparam logic [1:0] CH_A   = 2'd1;
   localparam logic [1:0] CH_B   = 2'd2;

   localparam logic [2:0] SPEED_OFF = 3'd0;
   localparam logic [2:0] SPEED_MIN = 3'd1;
   localparam logic [2:0] SPEED_MAX = 3'd5;

   localparam logic [2:0] RHYTHM_OFF    = 3'd0;
   localparam logic [2:0] RHYTHM_STEADY = 3'd1;
   localparam logic [2:0] RHYTHM_PULSE  = 3'd2;
   localparam logic [2:0] RHYTHM_SHORT  = 3'd3;
   localparam logic [2:0] RHYTHM_BURST  = 3'd4;
   localparam logic [2:0] RHYTHM_WAVE   = 3'd5;

   localparam logic [9:0] PULSE_PERIOD = 10'd39;
   localparam logic [9:0] PULSE_ON     = 10'd17;
   localparam logic [9:0] SHORT_PERIOD = 10'd18;
   localparam logic [9:0] SHORT_ON     = 10'd8;
   localparam logic [9:0] BURST_PERIOD = 10'd259;
   localparam logic [9:0] BURST_SOLID  = 10'd170;
   localparam logic [5:0] BURST_MOD    = 6'd17;
   localparam logic [5:0] BURST_ON_GT  = 6'd9;
   localparam logic [9:0] WAVE_PERIOD  = 10'd889;
   localparam logic [9:0] WAVE_HOLD    = 10'd680;
   localparam logic [9:0] WAVE_FIRST   = 10'd237;
   localparam logic [5:0] WAVE_MOD_LO  = 6'd35;
   localparam logic [5:0] WAVE_ON_GT   = 6'd30;
   localparam logic [5:0] WAVE_MOD_HI  = 6'd63;
   localparam logic [5:0] WAVE_OFF_GT  = 6'd26;

   // floor reciprocals scaled by 2^16
   localparam logic [15:0] BURST_RECIP   = 16'(65536 / 17);
   localparam logic [15:0] WAVE_RECIP_LO = 16'(65536 / 35);
   localparam logic [15:0] WAVE_RECIP_HI = 16'(65536 / 63);

   typedef struct packed {
      logic [KEY_COUNT-1:0] keys;
      logic                 charging;
      logic                 charge_full;
   } vmpc_tick_type;

   typedef struct packed {
      logic [1:0]                power_channel;
      logic [2:0]                speed_level;
      logic [2:0]                rhythm_mode;
      logic [6:0]                duty_level;
      logic                      motor_gate;
      logic [9:0]                pattern_time;
      logic [KEY_COUNT-1:0][7:0] key_hold_counts;
      logic [6:0]                led_timer;
      logic [7:0]                idle_count;
      logic                      led_latch;
   } vmpc_ctrl_type;

   typedef struct packed {
      logic motor_a_drive;
      logic motor_b_drive;
      logic led_on;
      logic sleep_request;
   } vmpc_result_type;

   function automatic logic [6:0] duty_of(input logic [2:0] speed);
      logic [6:0] duty;
      case (speed)
         3'd1:    duty = 7'd35;
         3'd2:    duty = 7'd50;
         3'd3:    duty = 7'd65;
         3'd4:    duty = 7'd80;
         3'd5:    duty = 7'd100;
         default: duty = 7'd0;
      endcase
      return duty;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/vmpc_slow.sv =====
// vmpc_slow: combinational slow step (led, key release, channel/speed/rhythm, idle)
// depends on vmpc_pkg
`default_nettype none

module vmpc_slow (
   input  wire vmpc_pkg::vmpc_ctrl_type cur,
   input  wire vmpc_pkg::vmpc_tick_type tk,
   output vmpc_pkg::vmpc_ctrl_type      nxt,
   output logic                         sleep_pulse
);

   function automatic logic [7:0] key_hold(input logic [7:0] cnt, input logic level);
      logic [7:0] sum;
      sum = cnt + 8'd1;
      if (!level) begin
         sum = '0;
      end else if (sum >= vmpc_pkg::HOLD_MAX) begin
         sum = vmpc_pkg::HOLD_MAX;
      end
      return sum;
   endfunction

   function automatic logic [2:0] next_mode(input logic [2:0] mode);
      logic [2:0] m;
      if (mode >= vmpc_pkg::RHYTHM_WAVE) begin
         m = vmpc_pkg::RHYTHM_STEADY;
      end else begin
         m = mode + 3'd1;
      end
      return m;
   endfunction

   // remainder by a constant through a scaled reciprocal and one correction
   function automatic logic [5:0] mod_const(input logic [9:0] t, input logic [5:0] d,
                                             input logic [15:0] m);
      logic [25:0] prod;
      logic [9:0]  q;
      logic [9:0]  r;
      prod = t * m;
      q    = prod[25:16];
      r    = t - 10'(q * d);
      if (r >= {4'd0, d}) begin
         r = r - {4'd0, d};
      end
      return r[5:0];
   endfunction

   vmpc_pkg::vmpc_ctrl_type               mid;
   logic [6:0]                            blink_phase;
   logic [vmpc_pkg::KEY_COUNT-1:0]        rel;
   logic [9:0]                            pt_step;
   logic [9:0]                            pt_wrap;
   logic [5:0]                            rem_burst;
   logic [5:0]                            rem_lo;
   logic [5:0]                            rem_hi;
   logic [7:0]                            idle_step;

   // led and keys
   always_comb begin
      mid         = cur;
      blink_phase = cur.led_timer + 7'd1;
      rel         = '0;
      if (tk.charging) begin
         if (tk.charge_full) begin
            mid.led_latch = 1'b1;
         end else begin
            if (blink_phase >= vmpc_pkg::BLINK_PERIOD) begin
               blink_phase = '0;
            end
            mid.led_timer = blink_phase;
            mid.led_latch = blink_phase < vmpc_pkg::BLINK_ON;
         end
      end else if (cur.led_timer != 7'd0) begin
         mid.led_latch = 1'b1;
         mid.led_timer = cur.led_timer - 7'd1;
      end else begin
         mid.led_latch = 1'b0;
      end

      rel[vmpc_pkg::KEY_POWER] = !tk.keys[vmpc_pkg::KEY_POWER] &&
         (cur.key_hold_counts[vmpc_pkg::KEY_POWER] >= vmpc_pkg::HOLD_MIN);
      mid.key_hold_counts[vmpc_pkg::KEY_POWER] =
         key_hold(cur.key_hold_counts[vmpc_pkg::KEY_POWER], tk.keys[vmpc_pkg::KEY_POWER]);
      if (rel[vmpc_pkg::KEY_POWER]) begin
         mid.led_timer = vmpc_pkg::FLASH_STEPS;
         if (cur.power_channel != vmpc_pkg::CH_OFF) begin
            mid.power_channel = vmpc_pkg::CH_OFF;
            mid.speed_level   = vmpc_pkg::SPEED_OFF;
            mid.rhythm_mode   = vmpc_pkg::RHYTHM_OFF;
         end else begin
            mid.power_channel = vmpc_pkg::CH_A;
            mid.speed_level   = vmpc_pkg::SPEED_MIN;
            mid.rhythm_mode   = vmpc_pkg::RHYTHM_STEADY;
         end
      end

      if (mid.power_channel != vmpc_pkg::CH_OFF) begin
         for (int i = vmpc_pkg::KEY_MODE_A; i < vmpc_pkg::KEY_COUNT; i++) begin
            rel[i] = !tk.keys[i] && (cur.key_hold_counts[i] >= vmpc_pkg::HOLD_MIN);
            mid.key_hold_counts[i] = key_hold(cur.key_hold_counts[i], tk.keys[i]);
         end
         if (rel[vmpc_pkg::KEY_MODE_A]) begin
            mid.led_timer = vmpc_pkg::FLASH_STEPS;
            if (mid.power_channel == vmpc_pkg::CH_A) begin
               mid.pattern_time = '0;
               mid.rhythm_mode  = next_mode(mid.rhythm_mode);
            end else begin
               mid.power_channel = vmpc_pkg::CH_A;
            end
         end
         if (rel[vmpc_pkg::KEY_MODE_B]) begin
            mid.led_timer = vmpc_pkg::FLASH_STEPS;
            if (mid.power_channel == vmpc_pkg::CH_B) begin
               mid.pattern_time = '0;
               mid.rhythm_mode  = next_mode(mid.rhythm_mode);
            end else begin
               mid.power_channel = vmpc_pkg::CH_B;
            end
         end
         if (rel[vmpc_pkg::KEY_FASTER]) begin
            mid.led_timer = vmpc_pkg::FLASH_STEPS;
            if (mid.speed_level >= vmpc_pkg::SPEED_MAX) begin
               mid.speed_level = vmpc_pkg::SPEED_MAX;
            end else begin
               mid.speed_level = mid.speed_level + 3'd1;
            end
         end
         if (rel[vmpc_pkg::KEY_SLOWER]) begin
            mid.led_timer = vmpc_pkg::FLASH_STEPS;
            if (mid.speed_level > vmpc_pkg::SPEED_MIN) begin
               mid.speed_level = mid.speed_level - 3'd1;
            end else begin
               mid.speed_level = vmpc_pkg::SPEED_MIN;
            end
         end
      end
   end

   // rhythm position
   assign pt_step = mid.pattern_time + 10'd1;

   always_comb begin
      case (mid.rhythm_mode)
         vmpc_pkg::RHYTHM_PULSE:
            pt_wrap = (pt_step >= vmpc_pkg::PULSE_PERIOD) ? '0 : pt_step;
         vmpc_pkg::RHYTHM_SHORT:
            pt_wrap = (pt_step >= vmpc_pkg::SHORT_PERIOD) ? '0 : pt_step;
         vmpc_pkg::RHYTHM_BURST:
            pt_wrap = (pt_step >= vmpc_pkg::BURST_PERIOD) ? '0 : pt_step;
         vmpc_pkg::RHYTHM_WAVE:
            pt_wrap = (pt_step >= vmpc_pkg::WAVE_PERIOD) ? '0 : pt_step;
         default:
            pt_wrap = pt_step;
      endcase
   end

   assign rem_burst = mod_const(pt_wrap, vmpc_pkg::BURST_MOD, vmpc_pkg::BURST_RECIP);
   assign rem_lo    = mod_const(pt_wrap, vmpc_pkg::WAVE_MOD_LO, vmpc_pkg::WAVE_RECIP_LO);
   assign rem_hi    = mod_const(pt_wrap, vmpc_pkg::WAVE_MOD_HI, vmpc_pkg::WAVE_RECIP_HI);
   assign idle_step = mid.idle_count + 8'd1;

   // duty, gate, idle
   always_comb begin
      nxt         = mid;
      sleep_pulse = 1'b0;
      if (mid.power_channel != vmpc_pkg::CH_OFF) begin
         if (mid.speed_level >= vmpc_pkg::SPEED_MIN && mid.speed_level <= vmpc_pkg::SPEED_MAX) begin
            nxt.duty_level = vmpc_pkg::duty_of(mid.speed_level);
         end
         case (mid.rhythm_mode)
            vmpc_pkg::RHYTHM_STEADY: begin
               nxt.motor_gate = 1'b1;
            end
            vmpc_pkg::RHYTHM_PULSE: begin
               nxt.pattern_time = pt_wrap;
               nxt.motor_gate   = pt_wrap < vmpc_pkg::PULSE_ON;
            end
            vmpc_pkg::RHYTHM_SHORT: begin
               nxt.pattern_time = pt_wrap;
               nxt.motor_gate   = pt_wrap < vmpc_pkg::SHORT_ON;
            end
            vmpc_pkg::RHYTHM_BURST: begin
               nxt.pattern_time = pt_wrap;
               nxt.motor_gate   = (pt_wrap > vmpc_pkg::BURST_SOLID) ||
                                  (rem_burst > vmpc_pkg::BURST_ON_GT);
            end
            vmpc_pkg::RHYTHM_WAVE: begin
               nxt.pattern_time = pt_wrap;
               if (pt_wrap > vmpc_pkg::WAVE_HOLD) begin
                  nxt.motor_gate = 1'b1;
               end else if (pt_wrap < vmpc_pkg::WAVE_FIRST) begin
                  nxt.motor_gate = rem_lo > vmpc_pkg::WAVE_ON_GT;
               end else if (pt_wrap < vmpc_pkg::WAVE_HOLD) begin
                  nxt.motor_gate = rem_hi <= vmpc_pkg::WAVE_OFF_GT;
               end
            end
            default: begin
            end
         endcase
      end
      if (mid.power_channel == vmpc_pkg::CH_OFF &&
          mid.key_hold_counts[vmpc_pkg::KEY_POWER] == 8'd0) begin
         if (idle_step > vmpc_pkg::IDLE_LIMIT) begin
            nxt.idle_count = '0;
            sleep_pulse    = 1'b1;
         end else begin
            nxt.idle_count = idle_step;
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/vmpc_core.sv =====
// vmpc_core: controller state registers, tick divider and motor pwm
// depends on vmpc_pkg and vmpc_slow
`default_nettype none

module vmpc_core (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      advance,
   input  wire vmpc_pkg::vmpc_tick_type   tk,
   output vmpc_pkg::vmpc_result_type      res
);

   logic [6:0]              tick_divider_ff;
   logic [6:0]              tick_divider_in;
   logic [6:0]              pwm_phase_ff;
   logic [6:0]              pwm_phase_in;
   logic                    drive_a_ff;
   logic                    drive_a_in;
   logic                    drive_b_ff;
   logic                    drive_b_in;
   vmpc_pkg::vmpc_ctrl_type ctrl_ff;
   vmpc_pkg::vmpc_ctrl_type ctrl_in;

   vmpc_pkg::vmpc_ctrl_type slow_ctrl;
   logic                    slow_sleep;
   logic [6:0]              tick_step;
   logic                    step_due;
   logic                    running;
   logic                    pwm_on;
   logic                    drive_a_mid;
   logic                    drive_b_mid;

   vmpc_slow u_slow (
      .cur         (ctrl_ff),
      .tk          (tk),
      .nxt         (slow_ctrl),
      .sleep_pulse (slow_sleep)
   );

   always_comb begin
      tick_step       = tick_divider_ff + 7'd1;
      step_due        = tick_step >= vmpc_pkg::TICKS_PER_STEP;
      tick_divider_in = step_due ? '0 : tick_step;

      running = (ctrl_ff.power_channel != vmpc_pkg::CH_OFF) && ctrl_ff.motor_gate;
      pwm_on  = pwm_phase_ff < ctrl_ff.duty_level;
      if (running) begin
         pwm_phase_in = ((pwm_phase_ff >= vmpc_pkg::PWM_PERIOD) ? 7'd0 : pwm_phase_ff) + 7'd1;
      end else begin
         pwm_phase_in = pwm_phase_ff;
      end
      drive_a_mid = (running && ctrl_ff.power_channel == vmpc_pkg::CH_A) ? pwm_on : drive_a_ff;
      drive_b_mid = (running && ctrl_ff.power_channel != vmpc_pkg::CH_A) ? pwm_on : drive_b_ff;

      ctrl_in = step_due ? slow_ctrl : ctrl_ff;

      // unselected or gated motor held off
      drive_a_in = drive_a_mid && ctrl_in.motor_gate &&
                   (ctrl_in.power_channel == vmpc_pkg::CH_A);
      drive_b_in = drive_b_mid && ctrl_in.motor_gate &&
                   (ctrl_in.power_channel == vmpc_pkg::CH_B);

      res.motor_a_drive = drive_a_in;
      res.motor_b_drive = drive_b_in;
      res.led_on        = ctrl_in.led_latch;
      res.sleep_request = step_due && slow_sleep;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_divider_ff <= '0;
         pwm_phase_ff    <= '0;
         drive_a_ff      <= 1'b0;
         drive_b_ff      <= 1'b0;
         ctrl_ff         <= '0;
      end else if (advance) begin
         tick_divider_ff <= tick_divider_in;
         pwm_phase_ff    <= pwm_phase_in;
         drive_a_ff      <= drive_a_in;
         drive_b_ff      <= drive_b_in;
         ctrl_ff         <= ctrl_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/vibration_motor_pattern_controller_unit.sv =====
// vibration_motor_pattern_controller_unit: top level, input beat register and result register
// depends on vmpc_pkg and vmpc_core
// an input beat is held in the input beat register; its result enters the result register on advance
// throughput: one beat per cycle while the result register is free or rsp_ready is high
// the input register refills while a result beat waits on rsp_ready only if it is empty
// reset: synchronous, active high; clears all controller state and both valid flags
`default_nettype none

module vibration_motor_pattern_controller_unit (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_ready,
   input  wire logic req_key_power,
   input  wire logic req_key_mode_a,
   input  wire logic req_key_mode_b,
   input  wire logic req_key_faster,
   input  wire logic req_key_slower,
   input  wire logic req_charging,
   input  wire logic req_charge_full,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   output logic      rsp_motor_a_drive,
   output logic      rsp_motor_b_drive,
   output logic      rsp_led_on,
   output logic      rsp_sleep_request
);

   logic                      in_valid_ff;
   logic                      in_valid_in;
   vmpc_pkg::vmpc_tick_type   in_beat_ff;
   vmpc_pkg::vmpc_tick_type   in_beat_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   vmpc_pkg::vmpc_result_type rsp_beat_ff;
   vmpc_pkg::vmpc_result_type core_res;
   logic                      advance;
   logic                      req_take;

   vmpc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .tk      (in_beat_ff),
      .res     (core_res)
   );

   always_comb begin
      advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
      req_ready = !in_valid_ff || advance;
      req_take  = req_valid && req_ready;

      in_beat_in.keys[vmpc_pkg::KEY_POWER]  = req_key_power;
      in_beat_in.keys[vmpc_pkg::KEY_MODE_A] = req_key_mode_a;
      in_beat_in.keys[vmpc_pkg::KEY_MODE_B] = req_key_mode_b;
      in_beat_in.keys[vmpc_pkg::KEY_FASTER] = req_key_faster;
      in_beat_in.keys[vmpc_pkg::KEY_SLOWER] = req_key_slower;
      in_beat_in.charging                   = req_charging;
      in_beat_in.charge_full                = req_charge_full;

      in_valid_in  = req_take || (in_valid_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_beat_ff <= in_beat_in;
      end
      if (advance) begin
         rsp_beat_ff <= core_res;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_motor_a_drive = rsp_beat_ff.motor_a_drive;
   assign rsp_motor_b_drive = rsp_beat_ff.motor_b_drive;
   assign rsp_led_on        = rsp_beat_ff.led_on;
   assign rsp_sleep_request = rsp_beat_ff.sleep_request;

endmodule

`default_nettype wire

// ===== sim/tb_vibration_motor_pattern_controller_unit.sv =====
// tb_vibration_motor_pattern_controller_unit: self-checking bench for the motor pattern controller
// timer ticks are planned in 100-tick slow steps, predicted beat by beat and checked field by field
// depends on vmpc_pkg and vibration_motor_pattern_controller_unit
`timescale 1ns / 1ps

module tb_vibration_motor_pattern_controller_unit;

   localparam int PHASE_ONE   = 350;
   localparam int PHASE_TWO   = 700;
   localparam int STALL_LIMIT = 2000;
   localparam int MAX_REPORTS = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_key_power = 1'b0;
   logic req_key_mode_a = 1'b0;
   logic req_key_mode_b = 1'b0;
   logic req_key_faster = 1'b0;
   logic req_key_slower = 1'b0;
   logic req_charging = 1'b0;
   logic req_charge_full = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_motor_a_drive;
   logic rsp_motor_b_drive;
   logic rsp_led_on;
   logic rsp_sleep_request;

   vibration_motor_pattern_controller_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_key_power     (req_key_power),
      .req_key_mode_a    (req_key_mode_a),
      .req_key_mode_b    (req_key_mode_b),
      .req_key_faster    (req_key_faster),
      .req_key_slower    (req_key_slower),
      .req_charging      (req_charging),
      .req_charge_full   (req_charge_full),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_motor_a_drive (rsp_motor_a_drive),
      .rsp_motor_b_drive (rsp_motor_b_drive),
      .rsp_led_on        (rsp_led_on),
      .rsp_sleep_request (rsp_sleep_request)
   );

   always #5 clock = ~clock;

   vmpc_pkg::vmpc_tick_type   tick_plan [$];
   vmpc_pkg::vmpc_result_type predicted_levels [$];

   int beats_sent = 0;
   int beats_in = 0;
   int n_results = 0;
   int n_errors = 0;
   int n_sleep = 0;
   int n_led = 0;
   int n_drive_a = 0;
   int n_drive_b = 0;
   int quiet_cycles = 0;
   logic chg_on = 1'b0;
   logic chg_full = 1'b0;

   // controller state as the bench sees it
   logic [6:0] m_div = '0;
   logic [6:0] m_phase = '0;
   logic [1:0] m_chan = vmpc_pkg::CH_OFF;
   logic [2:0] m_speed = vmpc_pkg::SPEED_OFF;
   logic [2:0] m_rhythm = vmpc_pkg::RHYTHM_OFF;
   logic [6:0] m_duty = '0;
   logic       m_gate = 1'b0;
   logic [9:0] m_ptime = '0;
   logic [7:0] m_hold [vmpc_pkg::KEY_COUNT] = '{default: '0};
   logic [6:0] m_led_t = '0;
   logic [7:0] m_idle = '0;
   logic       m_drv_a = 1'b0;
   logic       m_drv_b = 1'b0;
   logic       m_led = 1'b0;

   function automatic logic key_qualified(input int k, input logic level);
      if (level) begin
         m_hold[k] = m_hold[k] + 8'd1;
         if (m_hold[k] >= 8'd200) m_hold[k] = 8'd200;
         return 1'b0;
      end
      if (m_hold[k] >= 8'd8) begin
         m_hold[k] = '0;
         return 1'b1;
      end
      m_hold[k] = '0;
      return 1'b0;
   endfunction

   function automatic void cycle_rhythm();
      m_ptime = '0;
      m_rhythm = m_rhythm + 3'd1;
      if (m_rhythm > vmpc_pkg::RHYTHM_WAVE) m_rhythm = vmpc_pkg::RHYTHM_STEADY;
   endfunction

   function automatic void advance_rhythm();
      case (m_rhythm)
         vmpc_pkg::RHYTHM_STEADY: m_gate = 1'b1;
         vmpc_pkg::RHYTHM_PULSE: begin
            m_ptime = m_ptime + 10'd1;
            if (m_ptime >= 10'd39) m_ptime = '0;
            m_gate = m_ptime < 10'd17;
         end
         vmpc_pkg::RHYTHM_SHORT: begin
            m_ptime = m_ptime + 10'd1;
            if (m_ptime >= 10'd18) m_ptime = '0;
            m_gate = m_ptime < 10'd8;
         end
         vmpc_pkg::RHYTHM_BURST: begin
            m_ptime = m_ptime + 10'd1;
            if (m_ptime >= 10'd259) m_ptime = '0;
            m_gate = (m_ptime > 10'd170) ? 1'b1 : ((m_ptime % 10'd17) > 10'd9);
         end
         vmpc_pkg::RHYTHM_WAVE: begin
            m_ptime = m_ptime + 10'd1;
            if (m_ptime >= 10'd889) m_ptime = '0;
            if (m_ptime > 10'd680) m_gate = 1'b1;
            else if (m_ptime < 10'd237) m_gate = (m_ptime % 10'd35) > 10'd30;
            else if (m_ptime < 10'd680) m_gate = !((m_ptime % 10'd63) > 10'd26);
         end
         default: ;
      endcase
   endfunction

   function automatic logic slow_step(input vmpc_pkg::vmpc_tick_type t);
      // led first, then keys, then duty and rhythm, then idle tracking
      if (t.charging) begin
         if (t.charge_full) begin
            m_led = 1'b1;
         end else begin
            m_led_t = m_led_t + 7'd1;
            if (m_led_t >= 7'd100) m_led_t = '0;
            m_led = m_led_t < 7'd50;
         end
      end else if (m_led_t != '0) begin
         m_led = 1'b1;
         m_led_t = m_led_t - 7'd1;
      end else begin
         m_led = 1'b0;
      end

      if (key_qualified(vmpc_pkg::KEY_POWER, t.keys[vmpc_pkg::KEY_POWER])) begin
         m_led_t = 7'd100;
         if (m_chan != vmpc_pkg::CH_OFF) begin
            m_chan = vmpc_pkg::CH_OFF;
            m_speed = vmpc_pkg::SPEED_OFF;
            m_rhythm = vmpc_pkg::RHYTHM_OFF;
         end else begin
            m_chan = vmpc_pkg::CH_A;
            m_speed = vmpc_pkg::SPEED_MIN;
            m_rhythm = vmpc_pkg::RHYTHM_STEADY;
         end
      end
      if (m_chan != vmpc_pkg::CH_OFF) begin
         if (key_qualified(vmpc_pkg::KEY_MODE_A, t.keys[vmpc_pkg::KEY_MODE_A])) begin
            m_led_t = 7'd100;
            if (m_chan == vmpc_pkg::CH_A) cycle_rhythm();
            else m_chan = vmpc_pkg::CH_A;
         end
         if (key_qualified(vmpc_pkg::KEY_MODE_B, t.keys[vmpc_pkg::KEY_MODE_B])) begin
            m_led_t = 7'd100;
            if (m_chan == vmpc_pkg::CH_B) cycle_rhythm();
            else m_chan = vmpc_pkg::CH_B;
         end
         if (key_qualified(vmpc_pkg::KEY_FASTER, t.keys[vmpc_pkg::KEY_FASTER])) begin
            m_led_t = 7'd100;
            m_speed = m_speed + 3'd1;
            if (m_speed > vmpc_pkg::SPEED_MAX) m_speed = vmpc_pkg::SPEED_MAX;
         end
         if (key_qualified(vmpc_pkg::KEY_SLOWER, t.keys[vmpc_pkg::KEY_SLOWER])) begin
            m_led_t = 7'd100;
            if (m_speed > vmpc_pkg::SPEED_MIN) m_speed = m_speed - 3'd1;
            else m_speed = vmpc_pkg::SPEED_MIN;
         end
      end

      if (m_chan != vmpc_pkg::CH_OFF) begin
         case (m_speed)
            3'd1: m_duty = 7'd35;
            3'd2: m_duty = 7'd50;
            3'd3: m_duty = 7'd65;
            3'd4: m_duty = 7'd80;
            3'd5: m_duty = 7'd100;
            default: ;
         endcase
         advance_rhythm();
      end

      if (m_chan == vmpc_pkg::CH_OFF && m_hold[vmpc_pkg::KEY_POWER] == '0) begin
         m_idle = m_idle + 8'd1;
         if (m_idle > 8'd200) begin
            m_idle = '0;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic vmpc_pkg::vmpc_result_type step_controller(
         input vmpc_pkg::vmpc_tick_type t);
      vmpc_pkg::vmpc_result_type r;
      logic sleep_now;
      sleep_now = 1'b0;
      if (m_chan != vmpc_pkg::CH_OFF && m_gate) begin
         if (m_chan == vmpc_pkg::CH_A) m_drv_a = m_phase < m_duty;
         else m_drv_b = m_phase < m_duty;
         if (m_phase >= 7'd100) m_phase = '0;
         m_phase = m_phase + 7'd1;
      end
      m_div = m_div + 7'd1;
      if (m_div >= 7'd100) begin
         m_div = '0;
         sleep_now = slow_step(t);
      end
      if (!m_gate || m_chan == vmpc_pkg::CH_OFF) begin
         m_drv_a = 1'b0;
         m_drv_b = 1'b0;
      end
      if (m_chan != vmpc_pkg::CH_A) m_drv_a = 1'b0;
      if (m_chan != vmpc_pkg::CH_B) m_drv_b = 1'b0;
      r.motor_a_drive = m_drv_a;
      r.motor_b_drive = m_drv_b;
      r.led_on = m_led;
      r.sleep_request = sleep_now;
      return r;
   endfunction

   task automatic check_level(input string field, input logic want, input logic got);
      if (got !== want) begin
         n_errors++;
         if (n_errors <= MAX_REPORTS)
            $error("%s: expected %0b, got %0b", field, want, got);
      end
   endtask

   // one slow step: 99 ticks whose levels are not looked at, then the sampled tick
   task automatic push_step(input logic [vmpc_pkg::KEY_COUNT-1:0] held);
      vmpc_pkg::vmpc_tick_type t;
      repeat (99) begin
         t = vmpc_pkg::vmpc_tick_type'(7'($urandom));
         tick_plan.push_back(t);
      end
      t.keys = held;
      t.charging = chg_on;
      t.charge_full = chg_full;
      tick_plan.push_back(t);
   endtask

   task automatic pick_charger();
      int r;
      r = $urandom_range(9);
      chg_on = r >= 5;
      chg_full = (r >= 8) ? 1'b1 : ((r >= 5) ? 1'b0 : 1'($urandom));
   endtask

   // driver
   always @(negedge clock) begin : drive
      int send_pct;
      int recv_pct;
      vmpc_pkg::vmpc_tick_type nxt;
      if (beats_sent < PHASE_ONE) begin
         send_pct = 24;
         recv_pct = 85;
      end else if (beats_sent < PHASE_TWO) begin
         send_pct = 85;
         recv_pct = 24;
      end else begin
         send_pct = 0;
         recv_pct = 0;
      end
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= $urandom_range(99) >= recv_pct;
         if (!req_valid || beats_in == beats_sent) begin
            if (tick_plan.size() != 0 && $urandom_range(99) >= send_pct &&
                !((beats_sent == PHASE_ONE || beats_sent == PHASE_TWO) &&
                  predicted_levels.size() != 0)) begin
               nxt = tick_plan.pop_front();
               req_key_power   <= nxt.keys[vmpc_pkg::KEY_POWER];
               req_key_mode_a  <= nxt.keys[vmpc_pkg::KEY_MODE_A];
               req_key_mode_b  <= nxt.keys[vmpc_pkg::KEY_MODE_B];
               req_key_faster  <= nxt.keys[vmpc_pkg::KEY_FASTER];
               req_key_slower  <= nxt.keys[vmpc_pkg::KEY_SLOWER];
               req_charging    <= nxt.charging;
               req_charge_full <= nxt.charge_full;
               req_valid <= 1'b1;
               beats_sent++;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin : watch
      vmpc_pkg::vmpc_tick_type   seen;
      vmpc_pkg::vmpc_result_type oldest;
      vmpc_pkg::vmpc_result_type fresh;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            n_results++;
            if (predicted_levels.size() == 0) begin
               n_errors++;
               $error("result beat with nothing expected");
            end else begin
               oldest = predicted_levels.pop_front();
               check_level("motor_a_drive", oldest.motor_a_drive, rsp_motor_a_drive);
               check_level("motor_b_drive", oldest.motor_b_drive, rsp_motor_b_drive);
               check_level("led_on", oldest.led_on, rsp_led_on);
               check_level("sleep_request", oldest.sleep_request, rsp_sleep_request);
            end
         end
         if (req_valid && req_ready) begin
            seen.keys[vmpc_pkg::KEY_POWER]  = req_key_power;
            seen.keys[vmpc_pkg::KEY_MODE_A] = req_key_mode_a;
            seen.keys[vmpc_pkg::KEY_MODE_B] = req_key_mode_b;
            seen.keys[vmpc_pkg::KEY_FASTER] = req_key_faster;
            seen.keys[vmpc_pkg::KEY_SLOWER] = req_key_slower;
            seen.charging = req_charging;
            seen.charge_full = req_charge_full;
            fresh = step_controller(seen);
            n_drive_a += fresh.motor_a_drive;
            n_drive_b += fresh.motor_b_drive;
            n_led += fresh.led_on;
            n_sleep += fresh.sleep_request;
            predicted_levels.push_back(fresh);
            beats_in++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb_vibration_motor_pattern_controller_unit: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      // power held for eight steps with other keys pressed at random, ignored while off
      repeat (8) begin
         pick_charger();
         push_step(vmpc_pkg::KEY_COUNT'($urandom) |
                   (vmpc_pkg::KEY_COUNT'(1) << vmpc_pkg::KEY_POWER));
      end
      // power released: motor a on at the lowest speed with the feedback flash
      pick_charger();
      push_step(vmpc_pkg::KEY_COUNT'($urandom) &
                ~(vmpc_pkg::KEY_COUNT'(1) << vmpc_pkg::KEY_POWER));
      // one powered step with random keys, then free-running pwm ticks
      pick_charger();
      push_step(vmpc_pkg::KEY_COUNT'($urandom));
      repeat (50) tick_plan.push_back(vmpc_pkg::vmpc_tick_type'(7'($urandom)));

      repeat (8) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (tick_plan.size() != 0 || beats_in != beats_sent || predicted_levels.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);

      $display("ran %0d ticks over %0d slow steps, %0d result beats checked",
               beats_in, beats_in / 100, n_results);
      $display("motor a on %0d, motor b on %0d, led lit %0d, sleep pulses %0d",
               n_drive_a, n_drive_b, n_led, n_sleep);
      if (n_errors == 0) begin
         $display("tb_vibration_motor_pattern_controller_unit: clean");
      end else begin
         $display("tb_vibration_motor_pattern_controller_unit: errors");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/vmpc_pkg.sv
rtl/vmpc_slow.sv
rtl/vmpc_core.sv
rtl/vibration_motor_pattern_controller_unit.sv
sim/tb_vibration_motor_pattern_controller_unit.sv
